// ----- src/cau_pkg.sv -----
// Shared definitions for the complex arithmetic unit: operation and status codes,
// default widths and the queue depth. No dependencies.
package cau_pkg;

  localparam int CAU_DATA_WIDTH = 16;
  localparam int CAU_FRAC_BITS  = 8;
  localparam int CAU_QDEPTH     = 4;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MAG = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

endpackage

// ----- src/cau_front.sv -----
// Front end: input register and the partial products of each word.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
  parameter  int DATA_WIDTH = CAU_DATA_WIDTH,
  localparam int FE_W       = 3 + 20 * DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_req_type,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic [FE_W-1:0]              push_data
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
    logic signed [PW-1:0] rr;
    logic signed [PW-1:0] ii;
    logic signed [PW-1:0] ri;
    logic signed [PW-1:0] ir;
    logic signed [PW-1:0] aa;
    logic signed [PW-1:0] ai2;
    logic signed [PW-1:0] bb;
    logic signed [PW-1:0] bi2;
  } fe_t;

  logic                 vld_r, vld_nxt;
  logic                 load;
  logic [2:0]           op_r;
  logic signed [DW-1:0] are_r, aim_r, bre_r, bim_r;
  fe_t                  fe;

  assign in_ready = !vld_r || push_ready;
  assign load     = in_valid && in_ready;
  assign vld_nxt  = load || (vld_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r  <= in_req_type;
      are_r <= in_a_re;
      aim_r <= in_a_im;
      bre_r <= in_b_re;
      bim_r <= in_b_im;
    end
  end

  always_comb begin
    fe.op   = op_r;
    fe.a_re = are_r;
    fe.a_im = aim_r;
    fe.b_re = bre_r;
    fe.b_im = bim_r;
    fe.rr   = PW'(are_r) * PW'(bre_r);
    fe.ii   = PW'(aim_r) * PW'(bim_r);
    fe.ri   = PW'(are_r) * PW'(bim_r);
    fe.ir   = PW'(aim_r) * PW'(bre_r);
    fe.aa   = PW'(are_r) * PW'(are_r);
    fe.ai2  = PW'(aim_r) * PW'(aim_r);
    fe.bb   = PW'(bre_r) * PW'(bre_r);
    fe.bi2  = PW'(bim_r) * PW'(bim_r);
  end

  assign push_valid = vld_r;
  assign push_data  = fe;

endmodule

// ----- src/cau_queue.sv -----
// Short register queue between the front end and the back end.
// Depends on cau_pkg for the default depth.
module cau_queue import cau_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = CAU_QDEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != (AW+1)'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/cau_back.sv -----
// Back end: sums, rounding and saturation, pipelined restoring divider and square
// root (one quotient/root bit per stage), output register. Depends on cau_pkg.
module cau_back import cau_pkg::*; #(
  parameter  int DATA_WIDTH = CAU_DATA_WIDTH,
  parameter  int FRAC_BITS  = CAU_FRAC_BITS,
  localparam int FE_W       = 3 + 20 * DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic [FE_W-1:0]              pop_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic [1:0]                   out_status
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + 1;
  localparam int MW = 2 * DW;
  localparam int CW = MW + DW + 2;
  localparam int QW = DW + 2;
  localparam int NS = DW + 2;

  localparam logic signed [DW:0] SMAX    = {2'b00, {(DW-1){1'b1}}};
  localparam logic signed [DW:0] SMIN    = {2'b11, {(DW-1){1'b0}}};
  localparam logic [MW-1:0]      LIM_POS = MW'({(DW-1){1'b1}});
  localparam logic [MW-1:0]      LIM_NEG = LIM_POS + 1'b1;
  localparam logic [MW-1:0]      HALF    = (MW'(1) << FRAC_BITS) >> 1;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
    logic signed [PW-1:0] rr;
    logic signed [PW-1:0] ii;
    logic signed [PW-1:0] ri;
    logic signed [PW-1:0] ir;
    logic signed [PW-1:0] aa;
    logic signed [PW-1:0] ai2;
    logic signed [PW-1:0] bb;
    logic signed [PW-1:0] bi2;
  } fe_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [DW-1:0] sre;
    logic signed [DW-1:0] sim;
    logic                 sovf;
    logic signed [SW-1:0] nre;
    logic signed [SW-1:0] nim;
    logic [MW-1:0]        den;
    logic [MW-1:0]        sq;
  } p1_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [DW-1:0] sre;
    logic signed [DW-1:0] sim;
    logic                 sovf;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic [MW-1:0]        den;
    logic [CW-1:0]        rem_re;
    logic [CW-1:0]        rem_im;
    logic [QW-1:0]        q_re;
    logic [QW-1:0]        q_im;
    logic [MW-1:0]        sx;
    logic [DW-1:0]        root;
  } st_t;

  // {overflow, value} of a DW+1 bit sum clipped to DW bits
  function automatic logic [DW:0] sat_sum(input logic signed [DW:0] v);
    logic o;
    logic [DW-1:0] r;
    o = (v > SMAX) || (v < SMIN);
    r = o ? (v[DW] ? SMIN[DW-1:0] : SMAX[DW-1:0]) : v[DW-1:0];
    return {o, r};
  endfunction

  // {overflow, value} of rounded product magnitude with sign applied
  function automatic logic [DW:0] mul_round(input logic signed [SW-1:0] v);
    logic          n;
    logic [SW-1:0] a;
    logic [MW-1:0] r;
    logic [MW-1:0] lim;
    logic          o;
    logic [DW-1:0] m;
    n   = v[SW-1];
    a   = n ? -v : v;
    r   = (a[MW-1:0] + HALF) >> FRAC_BITS;
    lim = n ? LIM_NEG : LIM_POS;
    o   = r > lim;
    m   = o ? lim[DW-1:0] : r[DW-1:0];
    return {o, n ? -m : m};
  endfunction

  // {overflow, value} of a quotient magnitude with sign applied
  function automatic logic [DW:0] q_sat(input logic [QW-1:0] q, input logic n);
    logic [QW-1:0] lim;
    logic          o;
    logic [DW-1:0] m;
    lim = n ? QW'(LIM_NEG) : QW'(LIM_POS);
    o   = q > lim;
    m   = o ? lim[DW-1:0] : q[DW-1:0];
    return {o, n ? -m : m};
  endfunction

  logic                 en;
  fe_t                  hd;
  p1_t                  p1_r, p1_nxt;
  logic                 p1_vld_r;
  st_t                  stg_r   [0:NS];
  st_t                  stg_nxt [0:NS];
  logic [NS:0]          st_vld_r;
  logic                 out_valid_r;
  logic signed [DW-1:0] out_re_r, out_re_nxt;
  logic signed [DW-1:0] out_im_r, out_im_nxt;
  logic [1:0]           out_st_r, out_st_nxt;

  // whole back end advances when the output register is free or being taken
  assign en        = !out_valid_r || out_ready;
  assign pop_ready = en;
  assign hd        = pop_data;

  always_comb begin
    logic signed [DW:0] s_re, s_im;
    logic [DW:0]        t_re, t_im;
    if (hd.op == OP_SUB) begin
      s_re = (DW+1)'(hd.a_re) - (DW+1)'(hd.b_re);
      s_im = (DW+1)'(hd.a_im) - (DW+1)'(hd.b_im);
    end else begin
      s_re = (DW+1)'(hd.a_re) + (DW+1)'(hd.b_re);
      s_im = (DW+1)'(hd.a_im) + (DW+1)'(hd.b_im);
    end
    t_re = sat_sum(s_re);
    t_im = sat_sum(s_im);
    p1_nxt.op   = hd.op;
    p1_nxt.sre  = '0;
    p1_nxt.sim  = '0;
    p1_nxt.sovf = 1'b0;
    if (hd.op == OP_ADD || hd.op == OP_SUB) begin
      p1_nxt.sre  = t_re[DW-1:0];
      p1_nxt.sim  = t_im[DW-1:0];
      p1_nxt.sovf = t_re[DW] || t_im[DW];
    end
    if (hd.op == OP_MUL) begin
      p1_nxt.nre = SW'(hd.rr) - SW'(hd.ii);
      p1_nxt.nim = SW'(hd.ri) + SW'(hd.ir);
    end else begin
      p1_nxt.nre = SW'(hd.rr) + SW'(hd.ii);
      p1_nxt.nim = SW'(hd.ir) - SW'(hd.ri);
    end
    p1_nxt.den = MW'(hd.bb + hd.bi2);
    p1_nxt.sq  = MW'(hd.aa + hd.ai2);
  end

  // multiply rounding and saturation, and setup for the divide / root stages
  always_comb begin
    logic [SW-1:0] m_re, m_im;
    logic [DW:0]   r_re, r_im;
    m_re = p1_r.nre[SW-1] ? -p1_r.nre : p1_r.nre;
    m_im = p1_r.nim[SW-1] ? -p1_r.nim : p1_r.nim;
    r_re = mul_round(p1_r.nre);
    r_im = mul_round(p1_r.nim);
    stg_nxt[0].op   = p1_r.op;
    stg_nxt[0].sre  = p1_r.sre;
    stg_nxt[0].sim  = p1_r.sim;
    stg_nxt[0].sovf = p1_r.sovf;
    if (p1_r.op == OP_MUL) begin
      stg_nxt[0].sre  = r_re[DW-1:0];
      stg_nxt[0].sim  = r_im[DW-1:0];
      stg_nxt[0].sovf = r_re[DW] || r_im[DW];
    end
    stg_nxt[0].dz     = p1_r.den == '0;
    stg_nxt[0].neg_re = p1_r.nre[SW-1];
    stg_nxt[0].neg_im = p1_r.nim[SW-1];
    stg_nxt[0].den    = p1_r.den;
    stg_nxt[0].rem_re = CW'(m_re[MW-1:0]) << FRAC_BITS;
    stg_nxt[0].rem_im = CW'(m_im[MW-1:0]) << FRAC_BITS;
    stg_nxt[0].q_re   = '0;
    stg_nxt[0].q_im   = '0;
    stg_nxt[0].sx     = p1_r.sq;
    stg_nxt[0].root   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      st_vld_r <= '0;
    end else if (en) begin
      p1_vld_r <= pop_valid;
      st_vld_r <= {st_vld_r[NS-1:0], p1_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= p1_nxt;
      stg_r[0] <= stg_nxt[0];
    end
  end

  // stage j resolves quotient bit k = NS-1-j, and root bit k when k < DW
  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int K = NS - 1 - j;
    always_comb begin
      logic [CW-1:0]   t;
      logic [MW:0]     ts;
      t  = CW'(stg_r[j].den) << K;
      ts = '0;
      stg_nxt[j+1] = stg_r[j];
      if (stg_r[j].rem_re >= t) begin
        stg_nxt[j+1].rem_re  = stg_r[j].rem_re - t;
        stg_nxt[j+1].q_re[K] = 1'b1;
      end
      if (stg_r[j].rem_im >= t) begin
        stg_nxt[j+1].rem_im  = stg_r[j].rem_im - t;
        stg_nxt[j+1].q_im[K] = 1'b1;
      end
      if (K < DW) begin
        ts = ((MW+1)'(stg_r[j].root) << (K + 1)) + ((MW+1)'(1) << (2 * K));
        if ((MW+1)'(stg_r[j].sx) >= ts) begin
          stg_nxt[j+1].sx = stg_r[j].sx - ts[MW-1:0];
          stg_nxt[j+1].root[K % DW] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[j+1] <= stg_nxt[j+1];
      end
    end
  end

  always_comb begin
    logic [DW:0] d_re, d_im;
    st_t         f;
    f          = stg_r[NS];
    d_re       = q_sat(f.q_re, f.neg_re);
    d_im       = q_sat(f.q_im, f.neg_im);
    out_re_nxt = '0;
    out_im_nxt = '0;
    out_st_nxt = ST_OK;
    case (f.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        out_re_nxt = f.sre;
        out_im_nxt = f.sim;
        out_st_nxt = f.sovf ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (f.dz) begin
          out_st_nxt = ST_DZ;
        end else begin
          out_re_nxt = d_re[DW-1:0];
          out_im_nxt = d_im[DW-1:0];
          out_st_nxt = (d_re[DW] || d_im[DW]) ? ST_OVF : ST_OK;
        end
      end
      OP_MAG: begin
        out_re_nxt = f.root[DW-1] ? LIM_POS[DW-1:0] : f.root;
        out_st_nxt = f.root[DW-1] ? ST_OVF : ST_OK;
      end
      default: begin
        out_re_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r <= out_re_nxt;
      out_im_r <= out_im_nxt;
      out_st_r <= out_st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = out_re_r;
  assign out_res_im = out_im_r;
  assign out_status = out_st_r;

endmodule

// ----- src/complex_arithmetic_unit.sv -----
// Complex arithmetic unit, top level: front end, queue and back end.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
// Path: input register, queue, sum/product register, divide/root setup register,
//   DATA_WIDTH + 2 divider/root stages (one quotient bit each), output register.
// Throughput: one word per cycle for every operation while out_ready stays high.
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = CAU_DATA_WIDTH,
  parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_req_type,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic [1:0]                   out_status
);

  localparam int FE_W = 3 + 20 * DATA_WIDTH;

  logic            f_valid, f_ready;
  logic [FE_W-1:0] f_data;
  logic            q_valid, q_ready;
  logic [FE_W-1:0] q_data;

  cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_a_re     (in_a_re),
    .in_a_im     (in_a_im),
    .in_b_re     (in_b_re),
    .in_b_im     (in_b_im),
    .push_valid  (f_valid),
    .push_ready  (f_ready),
    .push_data   (f_data)
  );

  cau_queue #(.WIDTH(FE_W), .DEPTH(CAU_QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res_re (out_res_re),
    .out_res_im (out_res_im),
    .out_status (out_status)
  );

endmodule

// ----- src/cau_checker.sv -----
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit.
module cau_checker import cau_pkg::*; #(
  parameter int DATA_WIDTH = CAU_DATA_WIDTH
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_res_re,
  input logic [DATA_WIDTH-1:0] out_res_im,
  input logic [1:0]            out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_re) &&
      $stable(out_res_im) && $stable(out_status))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DZ |-> out_res_re == '0 && out_res_im == '0)
    else $error("divide by zero with nonzero result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_res_re (out_res_re),
  .out_res_im (out_res_im),
  .out_status (out_status)
);
